/* rtl/core/cla_pkg.sv */
// ============================================================================
// cla_pkg: shared types and constants of the console line assembler
// Holds the line store geometry, status codes, character codes and the
// structs that travel between the front, the command queue and the back.
// ============================================================================
package cla_pkg;

   // Line store geometry
   localparam int MAX_LINE = 63;
   localparam int IDX_W    = 6;
   localparam int CAP_W    = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Command queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Input operation codes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_EOF  = 1'b1;

   // Status codes carried on the last result of a run
   localparam logic [1:0] ST_READY   = 2'd0;
   localparam logic [1:0] ST_TRUNC   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_EOF     = 2'd3;

   // Character codes
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // One line command from front to back
   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] length;
   } cmd_type;

   // Line store write port driven by the front
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } store_wr_type;

endpackage

/* rtl/core/cla_front.sv */
// ============================================================================
// cla_front: input classification of the console line assembler
// Accepts input transactions, tracks line state and flags, writes line bytes
// to the store and queues one command per finished line, or at end of file and on each transaction after it.
// ============================================================================
module cla_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [cla_pkg::CAP_W-1:0]   csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [7:0]                  req_data_byte,
   input  logic                        q_full,
   output logic                        q_push,
   output cla_pkg::cmd_type            q_cmd,
   output cla_pkg::store_wr_type       store_wr,
   input  logic                        line_done
);

   logic [cla_pkg::CAP_W-1:0] cap_ff;
   logic [cla_pkg::IDX_W-1:0] fill_ff, fill_in;
   logic                      ovf_ff, ovf_in;
   logic                      bad_ff, bad_in;
   logic                      skip_ff, skip_in;
   logic                      ended_ff, ended_in;
   logic                      pend_ff, pend_in;
   logic                      accept;
   logic                      pending;
   cla_pkg::cmd_type          fin_cmd;

   // Stall while the queue is full or a ready line is still being read out of the store
   assign req_ready = !q_full && !pend_ff;
   assign accept    = req_valid && req_ready;
   assign pending   = (fill_ff != '0) || ovf_ff || bad_ff;

   // Work out the status of the line that would end now
   always_comb begin
      fin_cmd.length = '0;
      if (bad_ff) begin
         fin_cmd.status = cla_pkg::ST_INVALID;
      end else if (ovf_ff || ({1'b0, fill_ff} >= cap_ff)) begin
         fin_cmd.status = cla_pkg::ST_TRUNC;
      end else begin
         fin_cmd.status = cla_pkg::ST_READY;
         fin_cmd.length = fill_ff;
      end
   end

   // Classify the accepted transaction
   always_comb begin
      fill_in       = fill_ff;
      ovf_in        = ovf_ff;
      bad_in        = bad_ff;
      skip_in       = skip_ff;
      ended_in      = ended_ff;
      pend_in       = pend_ff && !line_done;
      q_push        = 1'b0;
      q_cmd.status  = cla_pkg::ST_EOF;
      q_cmd.length  = '0;
      store_wr.en   = 1'b0;
      store_wr.addr = fill_ff;
      store_wr.data = req_data_byte;
      if (accept) begin
         if (ended_ff) begin
            q_push = 1'b1;
         end else if (req_op == cla_pkg::OP_EOF) begin
            ended_in = 1'b1;
            skip_in  = 1'b0;
            q_push   = 1'b1;
            if (pending) begin
               q_cmd   = fin_cmd;
               pend_in = (fin_cmd.status == cla_pkg::ST_READY);
               fill_in = '0;
               ovf_in  = 1'b0;
               bad_in  = 1'b0;
            end
         end else if (skip_ff && req_data_byte == cla_pkg::CHAR_LF) begin
            skip_in = 1'b0;
         end else if (req_data_byte == cla_pkg::CHAR_CR ||
                      req_data_byte == cla_pkg::CHAR_LF) begin
            q_push  = 1'b1;
            q_cmd   = fin_cmd;
            pend_in = (fin_cmd.status == cla_pkg::ST_READY);
            fill_in = '0;
            ovf_in  = 1'b0;
            bad_in  = 1'b0;
            skip_in = (req_data_byte == cla_pkg::CHAR_CR);
         end else begin
            skip_in = 1'b0;
            if (req_data_byte == cla_pkg::CHAR_NUL) begin
               bad_in = 1'b1;
            end else if (!bad_ff && !ovf_ff) begin
               if (fill_ff == cla_pkg::IDX_W'(cla_pkg::MAX_LINE)) begin
                  ovf_in = 1'b1;
               end else begin
                  store_wr.en = 1'b1;
                  fill_in     = fill_ff + 1'b1;
               end
            end
         end
      end
   end

   // Hold capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cla_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Advance line state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         skip_ff  <= 1'b0;
         ended_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         bad_ff   <= bad_in;
         skip_ff  <= skip_in;
         ended_ff <= ended_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

/* rtl/core/cla_queue.sv */
// ============================================================================
// cla_queue: command queue between front and back
// A short first-in first-out queue of line commands so that either side can
// stall without holding up the other.
// ============================================================================
module cla_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cla_pkg::cmd_type    push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output cla_pkg::cmd_type    head_cmd
);

   cla_pkg::cmd_type           entry_ff [cla_pkg::QUEUE_DEPTH];
   logic [cla_pkg::QPTR_W-1:0] wptr_ff, wptr_in;
   logic [cla_pkg::QPTR_W-1:0] rptr_ff, rptr_in;
   logic [cla_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full       = (count_ff == cla_pkg::QCNT_W'(cla_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == cla_pkg::QPTR_W'(cla_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == cla_pkg::QPTR_W'(cla_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/cla_back.sv */
// ============================================================================
// cla_back: result generation of the console line assembler
// Owns the line store, takes commands from the queue and emits the result
// run of each: the line bytes of a ready line, then one status item.
// ============================================================================
module cla_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cla_pkg::store_wr_type       store_wr,
   input  logic                        q_valid,
   input  cla_pkg::cmd_type            q_cmd,
   output logic                        q_pop,
   output logic                        line_done,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_line_byte,
   output logic [1:0]                  rsp_status,
   output logic [cla_pkg::IDX_W-1:0]   rsp_line_length,
   output logic                        rsp_last
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_BYTES = 2'd1;
   localparam logic [1:0] S_LAST  = 2'd2;

   logic [7:0]                line_store [cla_pkg::MAX_LINE];
   logic [7:0]                rd_data_ff;
   logic [cla_pkg::IDX_W-1:0] rd_addr;

   logic [1:0]                state_ff, state_in;
   logic [cla_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [cla_pkg::IDX_W-1:0] len_ff, len_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic [1:0]                out_status_ff, out_status_in;
   logic [cla_pkg::IDX_W-1:0] out_len_ff, out_len_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_free;

   assign out_free        = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_line_byte   = out_byte_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_line_length = out_len_ff;
   assign rsp_last        = out_last_ff;
   assign rd_addr         = idx_in;

   // Sequence the result run of the head command
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;
      q_pop         = 1'b0;
      line_done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_cmd.status == cla_pkg::ST_READY && q_cmd.length != '0) begin
                  idx_in   = '0;
                  len_in   = q_cmd.length;
                  state_in = S_BYTES;
               end else begin
                  out_valid_in  = 1'b1;
                  out_byte_in   = '0;
                  out_status_in = q_cmd.status;
                  out_len_in    = q_cmd.length;
                  out_last_in   = 1'b1;
                  line_done     = (q_cmd.status == cla_pkg::ST_READY);
               end
            end
         end
         S_BYTES: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = rd_data_ff;
               out_status_in = cla_pkg::ST_READY;
               out_len_in    = '0;
               out_last_in   = 1'b0;
               idx_in        = idx_ff + 1'b1;
               if (idx_in == len_ff) begin
                  state_in = S_LAST;
               end
            end
         end
         S_LAST: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = '0;
               out_status_in = cla_pkg::ST_READY;
               out_len_in    = len_ff;
               out_last_in   = 1'b1;
               line_done     = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      len_ff        <= len_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
   end

   // Write line store, read it one entry ahead of the output
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         line_store[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= line_store[rd_addr];
   end

endmodule

/* rtl/core/console_line_assembler_core.sv */
// ============================================================================
// console_line_assembler_core: line assembly from a received byte stream
// Top level joining the input front, the command queue and the result back.
// ============================================================================
// Bytes go in one transaction each; CR or LF ends a line and an LF right
// after a CR is dropped. Each line gives a run of results on rsp_: for a ready
// line, its bytes one per cycle while rsp_ready holds and then a last item
// with status and length; for a truncated or invalid line, or end of file,
// one last item. A ready line of n bytes is read out of the line store at
// one byte per cycle while rsp_ready holds, and the front accepts no
// further item until that readout completes, as both share the single
// line store. A two-entry command queue lets the front keep accepting
// while the back waits on rsp_ready for status-only results. The
// capacity register (reset 64) may be written only while the block is idle.
module console_line_assembler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_line_byte,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_line_length,
   output logic        rsp_last
);

   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_valid;
   logic                  line_done;
   cla_pkg::cmd_type      push_cmd;
   cla_pkg::cmd_type      head_cmd;
   cla_pkg::store_wr_type store_wr;

   cla_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd),
      .store_wr      (store_wr),
      .line_done     (line_done)
   );

   cla_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   cla_back u_back (
      .clock           (clock),
      .reset           (reset),
      .store_wr        (store_wr),
      .q_valid         (q_valid),
      .q_cmd           (head_cmd),
      .q_pop           (q_pop),
      .line_done       (line_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_byte   (rsp_line_byte),
      .rsp_status      (rsp_status),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

endmodule
